### rtl/uxg_pkg.sv
// Shared constants and types for the upward expander gain block.
package uxg_pkg;

  localparam int MAX_CHANNELS_DEF = 2;
  localparam int SAMPLE_BITS_DEF  = 24;

  // Width of each operand of the shared multiplier.
  localparam int MUL_W = 32;

  localparam logic signed [15:0] FLOOR_DB    = -16'sd25600;
  localparam logic [15:0]        SMOOTH_COEF = 16'd22938;
  localparam logic [18:0]        DB_PER_LOG2 = 19'd394566;
  localparam logic [21:0]        LOG2_PER_DB = 22'd2786635;
  localparam logic [15:0]        SLOPE_MIN   = 16'd655;
  localparam logic [15:0]        SLOPE_MAX   = 16'd64880;
  localparam logic [14:0]        ENV_FLOOR_MAG = 15'd25600;
  localparam logic [16:0]        MANT_ONE    = 17'd65536;

  // Horner coefficients of the 2^f mantissa polynomial, innermost first.
  localparam logic [15:0] POLY_C [3] = '{16'd5223, 16'd14700, 16'd45613};

  typedef enum logic [2:0] {
    REG_ENABLED   = 3'd0,
    REG_ACTIVE_CH = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_RANGE     = 3'd4,
    REG_SLOPE     = 3'd5,
    REG_OFFSET    = 3'd6
  } reg_idx_t;

endpackage

### rtl/uxg_mul.sv
// Shared unsigned multiplier with a registered product.
module uxg_mul (
  input  logic                          clk,
  input  logic [uxg_pkg::MUL_W-1:0]     a,
  input  logic [uxg_pkg::MUL_W-1:0]     b,
  output logic [2*uxg_pkg::MUL_W-1:0]   prod
);
  import uxg_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

### rtl/upward_expander_gain.sv
// Upward expander: peak envelope in dB drives a smoothed boost applied to each channel.
//
// Input channel s_*: one frame per transfer (left and right samples and a scene level).
// Output channel m_*: the gained samples and the smoothed gain in dB, one per frame.
// Config channel cfg_*: register index and data; always ready, write only while idle.
// One frame is handled at a time by a sequencer around a single shared multiplier.
// s_tready is high only while the sequencer is idle. With expansion on, the time from transfer to
// result depends on the top bit index of the peak magnitude and on the number of detection
// channels (1 or 2); a silent frame skips the log. The leading-one search (one bit per cycle)
// and the 16 squaring steps of the log dominate that time. With expansion off, the samples
// pass through unchanged.
// The result sits in an output register, so a stalled receiver only blocks the block
// once the next result is finished; the sequencer then waits in its last state.
// Reset restores the register defaults, sets each envelope to -100 dB and the smoothed
// gain to 0 dB, and empties the output register.
module upward_expander_gain #(
  parameter int MAX_CHANNELS = uxg_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = uxg_pkg::SAMPLE_BITS_DEF,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 16 + 7) / 8) * 8,
  localparam int OUT_W = ((2 * SAMPLE_BITS + 15 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // sample_left, sample_right, scene_db
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // out_left, out_right, gain_db
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import uxg_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int ENV_N = (MAX_CHANNELS > 2) ? 2 : MAX_CHANNELS;

  typedef enum logic [18:0] {
    S_IDLE = 19'd1,
    S_NORM = 19'd2,
    S_SQ   = 19'd4,
    S_SQN  = 19'd8,
    S_DBM  = 19'd16,
    S_DBW  = 19'd32,
    S_ENVM = 19'd64,
    S_ENVW = 19'd128,
    S_TGTM = 19'd256,
    S_TGTW = 19'd512,
    S_SMM  = 19'd1024,
    S_SMW  = 19'd2048,
    S_EXPM = 19'd4096,
    S_EXPW = 19'd8192,
    S_POLM = 19'd16384,
    S_POLW = 19'd32768,
    S_APPM = 19'd65536,
    S_APPW = 19'd131072,
    S_OUT  = 19'd262144
  } state_t;

  state_t state;

  // Configuration registers.
  logic                en_r;
  logic [1:0]          act_r;
  logic [15:0]         atk_r;
  logic [15:0]         rel_r;
  logic [14:0]         range_r;
  logic [15:0]         slope_r;
  logic signed [15:0]  offset_r;

  // Frame and working registers.
  logic [SB-1:0]       samp [2];
  logic signed [15:0]  scene;
  logic [31:0]         x;
  logic [4:0]          p;
  logic [15:0]         frac;
  logic [3:0]          k;
  logic signed [15:0]  pdb;
  logic signed [15:0]  env [ENV_N];
  logic [15:0]         sg;
  logic [14:0]         target;
  logic [5:0]          ip;
  logic [15:0]         f;
  logic [16:0]         t;
  logic [1:0]          j;
  logic                ch;
  logic [SB-1:0]       res [2];
  logic                out_valid;
  logic [SB-1:0]       out_l;
  logic [SB-1:0]       out_r;
  logic [14:0]         out_g;

  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  logic [2*MUL_W-1:0]  prod;

  // Combinational helpers.
  logic                use_two;
  logic [SB-1:0]       in_l;
  logic [SB-1:0]       in_r;
  logic [SB-1:0]       mag_l;
  logic [SB-1:0]       mag_r;
  logic [SB-1:0]       peak_in;
  logic [32:0]         sq_t;
  logic [20:0]         log_d;
  logic [63:0]         prod_db;
  logic [16:0]         dbneg;
  logic [63:0]         prod_rnd;
  logic [31:0]         step_s;
  logic signed [15:0]  env_cur;
  logic signed [16:0]  env_diff;
  logic [16:0]         env_mag;
  logic [15:0]         env_k;
  logic [15:0]         env_new;
  logic signed [15:0]  env_max;
  logic signed [16:0]  thr;
  logic signed [17:0]  over;
  logic [17:0]         over_mag;
  logic [15:0]         sl;
  logic signed [16:0]  sm_diff;
  logic [16:0]         sm_mag;
  logic [15:0]         sg_new;
  logic [16:0]         mant;
  logic [SB-1:0]       smag;
  logic                ap_neg;
  logic [63:0]         ap_lim;
  logic [63:0]         ap_rnd;
  logic [63:0]         ap_r;
  logic [63:0]         ap_y;
  logic [5:0]          ap_shr;
  logic [5:0]          ap_sh;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = out_valid;
  assign m_tdata   = OUT_W'({out_g, out_r, out_l});

  assign use_two = act_r[1] && (ENV_N > 1);

  assign in_l    = s_tdata[SB-1:0];
  assign in_r    = s_tdata[2*SB-1:SB];
  assign mag_l   = in_l[SB-1] ? (~in_l + 1'b1) : in_l;
  assign mag_r   = in_r[SB-1] ? (~in_r + 1'b1) : in_r;
  assign peak_in = (use_two && (mag_r > mag_l)) ? mag_r : mag_l;

  assign sq_t     = prod[63:31];
  assign log_d    = {5'(SB - 1), 16'd0} - {p, frac};
  assign prod_db  = prod + (64'd1 << 23);
  assign dbneg    = prod_db[40:24];
  assign prod_rnd = prod + 64'd32768;
  assign step_s   = prod_rnd[47:16];

  assign env_cur  = env[ch];
  assign env_diff = {pdb[15], pdb} - {env_cur[15], env_cur};
  assign env_mag  = env_diff[16] ? 17'(-env_diff) : 17'(env_diff);
  assign env_k    = (pdb > env_cur) ? atk_r : rel_r;
  assign env_new  = env_diff[16] ? (16'(env_cur) - step_s[15:0])
                                  : (16'(env_cur) + step_s[15:0]);

  assign env_max  = (use_two && (env[ENV_N-1] > env[0])) ? env[ENV_N-1] : env[0];
  assign thr      = {scene[15], scene} + {offset_r[15], offset_r};
  assign over     = {{2{env_max[15]}}, env_max} - {thr[16], thr};
  assign over_mag = over[17] ? 18'(-over) : 18'd0;
  assign sl       = (slope_r < SLOPE_MIN) ? SLOPE_MIN :
                    ((slope_r > SLOPE_MAX) ? SLOPE_MAX : slope_r);

  assign sm_diff  = $signed({2'b00, target}) - $signed({1'b0, sg});
  assign sm_mag   = sm_diff[16] ? 17'(-sm_diff) : 17'(sm_diff);
  assign sg_new   = sm_diff[16] ? (sg - step_s[15:0]) : (sg + step_s[15:0]);

  assign mant     = MANT_ONE + t;
  assign smag     = samp[ch][SB-1] ? (~samp[ch] + 1'b1) : samp[ch];

  // Rounds or saturates the scaled magnitude of one sample and restores its sign.
  always_comb begin
    ap_neg = samp[ch][SB-1];
    ap_lim = ap_neg ? (64'd1 << (SB - 1)) : ((64'd1 << (SB - 1)) - 64'd1);
    if (ip < 6'd16) begin
      ap_sh  = 6'd0;
      ap_shr = 6'd16 - ip;
      ap_rnd = 64'd1 << (ap_shr - 6'd1);
      ap_r   = (prod + ap_rnd) >> ap_shr;
    end else begin
      ap_shr = 6'd0;
      ap_rnd = 64'd0;
      ap_sh  = ip - 6'd16;
      ap_r   = ((ap_sh >= 6'd40) || (prod > (ap_lim >> ap_sh))) ? ap_lim : (prod << ap_sh);
    end
    if (ap_r > ap_lim) begin
      ap_r = ap_lim;
    end
    ap_y = ap_neg ? (~ap_r + 64'd1) : ap_r;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ: begin
        mul_a = x;
        mul_b = x;
      end
      S_DBM: begin
        mul_a = 32'(log_d);
        mul_b = 32'(DB_PER_LOG2);
      end
      S_ENVM: begin
        mul_a = 32'(env_mag);
        mul_b = 32'(env_k);
      end
      S_TGTM: begin
        mul_a = 32'(over_mag);
        mul_b = 32'(sl);
      end
      S_SMM: begin
        mul_a = 32'(sm_mag);
        mul_b = 32'(SMOOTH_COEF);
      end
      S_EXPM: begin
        mul_a = 32'(sg);
        mul_b = 32'(LOG2_PER_DB);
      end
      S_POLM: begin
        mul_a = 32'(POLY_C[j]) + 32'(t);
        mul_b = 32'(f);
      end
      S_APPM: begin
        mul_a = 32'(smag);
        mul_b = 32'(mant);
      end
      default: begin
      end
    endcase
  end

  uxg_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      en_r     <= 1'b1;
      act_r    <= 2'd2;
      atk_r    <= 16'd6554;
      rel_r    <= 16'd655;
      range_r  <= 15'd1536;
      slope_r  <= 16'd32768;
      offset_r <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ENABLED:   en_r     <= cfg_data[0];
        REG_ACTIVE_CH: act_r    <= cfg_data[1:0];
        REG_ATTACK:    atk_r    <= cfg_data;
        REG_RELEASE:   rel_r    <= cfg_data;
        REG_RANGE:     range_r  <= cfg_data[14:0];
        REG_SLOPE:     slope_r  <= cfg_data;
        REG_OFFSET:    offset_r <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Sequencer and the state it updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= 1'b0;
      sg    <= 16'd0;
      for (int i = 0; i < ENV_N; i++) begin
        env[i] <= FLOOR_DB;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            samp[0] <= in_l;
            samp[1] <= in_r;
            scene   <= $signed(s_tdata[2*SB+15:2*SB]);
            ch      <= 1'b0;
            x       <= 32'(peak_in);
            p       <= 5'd31;
            if (!en_r) begin
              res[0] <= in_l;
              res[1] <= in_r;
              state  <= S_OUT;
            end else if (peak_in == '0) begin
              pdb   <= FLOOR_DB;
              state <= S_ENVM;
            end else begin
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (x[31]) begin
            k     <= 4'd0;
            frac  <= 16'd0;
            state <= S_SQ;
          end else begin
            x <= x << 1;
            p <= p - 5'd1;
          end
        end
        S_SQ: begin
          state <= S_SQN;
        end
        S_SQN: begin
          frac <= {frac[14:0], sq_t[32]};
          x    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
          k    <= k + 4'd1;
          state <= (k == 4'd15) ? S_DBM : S_SQ;
        end
        S_DBM: begin
          state <= S_DBW;
        end
        S_DBW: begin
          if (dbneg > {2'b00, ENV_FLOOR_MAG}) begin
            pdb <= FLOOR_DB;
          end else begin
            pdb <= -$signed({1'b0, dbneg[14:0]});
          end
          state <= S_ENVM;
        end
        S_ENVM: begin
          state <= S_ENVW;
        end
        S_ENVW: begin
          env[ch] <= $signed(env_new);
          if (!ch && use_two) begin
            ch    <= 1'b1;
            state <= S_ENVM;
          end else begin
            ch    <= 1'b0;
            state <= S_TGTM;
          end
        end
        S_TGTM: begin
          state <= S_TGTW;
        end
        S_TGTW: begin
          target <= (step_s > {17'd0, range_r}) ? range_r : step_s[14:0];
          state  <= S_SMM;
        end
        S_SMM: begin
          state <= S_SMW;
        end
        S_SMW: begin
          sg    <= sg_new;
          state <= S_EXPM;
        end
        S_EXPM: begin
          state <= S_EXPW;
        end
        S_EXPW: begin
          ip    <= step_s[21:16];
          f     <= step_s[15:0];
          t     <= 17'd0;
          j     <= 2'd0;
          state <= S_POLM;
        end
        S_POLM: begin
          state <= S_POLW;
        end
        S_POLW: begin
          t <= prod[32:16];
          if (j == 2'd2) begin
            ch    <= 1'b0;
            state <= S_APPM;
          end else begin
            j     <= j + 2'd1;
            state <= S_POLM;
          end
        end
        S_APPM: begin
          state <= S_APPW;
        end
        S_APPW: begin
          res[ch] <= ap_y[SB-1:0];
          if (!ch) begin
            ch    <= 1'b1;
            state <= S_APPM;
          end else begin
            ch    <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register, loaded when the previous result has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && (!out_valid || m_tready)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!out_valid || m_tready)) begin
      out_l <= res[0];
      out_r <= res[1];
      out_g <= sg[14:0];
    end
  end

  a_norm_mantissa: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ) |-> x[31])
    else $error("log mantissa not normalized before squaring");

  a_env_range: assert property (@(posedge clk) disable iff (rst)
    (env[0] <= 16'sd0) && (env[0] >= FLOOR_DB))
    else $error("channel envelope left the -100 to 0 dB range");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    !sg[15])
    else $error("smoothed gain exceeds the 15-bit range");

  a_mant_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPM) |-> mant[16])
    else $error("gain mantissa below one");

endmodule
